[hdl/pcwrl_pkg.sv]
// Package for the per-client window rate limiter.
// Holds the item types, the cell command and chain types, and the field widths.
// No dependencies.
package pcwrl_pkg;

    localparam int KEY_W   = 48;
    localparam int CNT_W   = 32;
    localparam int LIVE_W  = 7;
    localparam int WIN_W   = 21;
    localparam int ELAP_W  = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] COUNT_SAT = '1;
    localparam logic [WIN_W-1:0] WINDOW_CAP = WIN_W'(1048576);

    // Function codes
    localparam logic [1:0] FN_SEND = 2'd0;
    localparam logic [1:0] FN_RECV = 2'd1;
    localparam logic [1:0] FN_TICK = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_TICKS = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] client_ip;
        logic [15:0] client_port;
        logic [31:0] byte_count;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic              tracked;
        logic              window_reset;
        logic [31:0]       byte_total;
        logic [LIVE_W-1:0] live_entries;
    } t_out_item;

    // Broadcast command to every cell
    typedef struct packed {
        logic             wr;
        logic             alloc;
        logic             evict;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] sent;
        logic [CNT_W-1:0] recv;
    } t_cell_cmd;

    // Data handed from one cell to the next
    typedef struct packed {
        logic             taken;   // a free entry was seen upstream
        logic             hit;     // a matching entry was seen upstream
        logic [CNT_W-1:0] sent;    // counts of the matching entry
        logic [CNT_W-1:0] recv;
    } t_chain;

    // Per-cell status
    typedef struct packed {
        logic valid;
        logic hit;
        logic first;   // lowest free entry
    } t_cell_stat;

endpackage

[hdl/pcwrl_cell.sv]
// One table cell: a client key with its sent and received counts.
// Depends on pcwrl_pkg.
module pcwrl_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcwrl_pkg::t_cell_cmd i_cmd,
    input  logic                 i_sel,
    input  pcwrl_pkg::t_chain    i_chain,
    output pcwrl_pkg::t_chain    o_chain,
    output pcwrl_pkg::t_cell_stat o_stat
);
    import pcwrl_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_sent;
    logic [CNT_W-1:0] r_recv;
    logic             hit;

    assign hit = r_valid && (r_key == i_cmd.key);

    // Pass match and free-slot information downstream
    always_comb begin
        o_chain.taken = i_chain.taken | ~r_valid;
        o_chain.hit   = i_chain.hit | hit;
        o_chain.sent  = i_chain.sent | (hit ? r_sent : '0);
        o_chain.recv  = i_chain.recv | (hit ? r_recv : '0);
        o_stat.valid  = r_valid;
        o_stat.hit    = hit;
        o_stat.first  = ~r_valid & ~i_chain.taken;
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr && i_sel && i_cmd.alloc) begin
            r_valid <= 1'b1;
        end else if (i_cmd.evict && r_valid && r_sent == '0 && r_recv == '0) begin
            r_valid <= 1'b0;
        end
    end

    // Key and counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_sel) begin
            if (i_cmd.alloc) begin
                r_key <= i_cmd.key;
            end
            r_sent <= i_cmd.sent;
            r_recv <= i_cmd.recv;
        end else if (i_cmd.evict) begin
            r_sent <= '0;
            r_recv <= '0;
        end
    end

endmodule

[hdl/per_client_window_rate_limiter.sv]
// Top level of the per-client window rate limiter: control sequencer and cell row.
// Depends on pcwrl_pkg and pcwrl_cell.
//
// Channel | Direction | Handshake            | Payload
// in      | input     | i_in_valid/o_in_stall | i_in_item  (t_in_item)
// out     | output    | o_out_valid/i_out_stall | o_out_item (t_out_item)
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A send, receive or plain tick item passes through capture, the key match along
// the cell row, and the cell update with the result register. A tick that ends
// the window adds a sweep over the valid flags that recounts the live entries.
// Reset is synchronous and empties the table. A stalled result holds the update
// step, or the last step of the sweep, until the output register frees up.
module per_client_window_rate_limiter #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  pcwrl_pkg::t_in_item                  i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output pcwrl_pkg::t_out_item                 o_out_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pcwrl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);
    import pcwrl_pkg::*;

    localparam int N    = TABLE_ENTRIES;
    localparam int CW   = $clog2(N + 1);
    localparam int IW   = (N > 1) ? $clog2(N) : 1;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_UPD, S_CNT} t_state;

    t_state           r_state;
    t_in_item         r_item;
    logic [CNT_W-1:0] r_max;
    logic [WIN_W-1:0] r_wticks;
    logic [ELAP_W-1:0] r_elapsed;
    logic [CW-1:0]    r_live;
    logic [CW-1:0]    r_cnt;
    logic [IW-1:0]    r_scan;
    logic [N-1:0]     r_sel;
    logic             r_hit;
    logic             r_free;
    logic [CNT_W-1:0] r_cur_sent;
    logic [CNT_W-1:0] r_cur_recv;
    logic             r_out_valid;
    t_out_item        r_out;

    t_chain           chain [N+1];
    t_cell_stat       stat  [N];
    logic [N-1:0]     valid_vec;
    logic [N-1:0]     n_sel;
    t_cell_cmd        cmd;

    logic             in_acc;
    logic             slot_free;
    logic             tracked;
    logic             accepted;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] new_sent;
    logic [CNT_W-1:0] new_recv;
    logic [CNT_W:0]   sent_sum;
    logic [WIN_W-1:0] limit;
    logic [WIN_W-1:0] next_elapsed;
    logic             win_end;
    logic             is_send;
    logic             is_recv;
    logic             is_tick;
    logic [CW-1:0]    n_live;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign slot_free   = !r_out_valid || !i_out_stall;

    // Cell row
    assign chain[0] = '0;
    for (genvar g = 0; g < N; g++) begin : g_cell
        pcwrl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_sel   (r_sel[g]),
            .i_chain (chain[g]),
            .o_chain (chain[g+1]),
            .o_stat  (stat[g])
        );
        assign valid_vec[g] = stat[g].valid;
        assign n_sel[g]     = chain[N].hit ? stat[g].hit : stat[g].first;
    end

    // Item decode and result computation
    always_comb begin
        is_send  = (r_item.func == FN_SEND);
        is_recv  = (r_item.func == FN_RECV);
        is_tick  = (r_item.func == FN_TICK);
        tracked  = (is_send || is_recv) && (r_hit || r_free);
        sent_sum = {1'b0, r_cur_sent} + {1'b0, r_item.byte_count};
        new_sent = sent_sum[CNT_W] ? COUNT_SAT : sent_sum[CNT_W-1:0];
        new_recv = r_cur_recv;
        accepted = 1'b0;
        total    = '0;
        if (is_send) begin
            accepted = tracked;
            total    = tracked ? new_sent : '0;
        end else if (is_recv) begin
            if (r_cur_recv > r_max || r_item.byte_count > (r_max - r_cur_recv)) begin
                total = r_cur_recv;
            end else begin
                accepted = 1'b1;
                new_recv = r_cur_recv + r_item.byte_count;
                total    = new_recv;
            end
        end
        // Window length, clamped to 1..2^20
        if (r_wticks == '0) begin
            limit = WIN_W'(1);
        end else if (r_wticks > WINDOW_CAP) begin
            limit = WINDOW_CAP;
        end else begin
            limit = r_wticks;
        end
        next_elapsed = {1'b0, r_elapsed} + WIN_W'(1);
        win_end      = is_tick && (next_elapsed >= limit);
        n_live       = (tracked && !r_hit) ? r_live + CW'(1) : r_live;

        cmd.key   = {r_item.client_ip, r_item.client_port};
        cmd.alloc = !r_hit;
        cmd.wr    = (r_state == S_UPD) && slot_free && tracked;
        cmd.evict = (r_state == S_UPD) && win_end;
        cmd.sent  = is_send ? new_sent : r_cur_sent;
        cmd.recv  = is_recv ? new_recv : r_cur_recv;
    end

    // Sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= CNT_W'(65536);
            r_wticks    <= WIN_W'(1000);
            r_elapsed   <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MAX_BYTES: r_max    <= i_cfg_data;
                    REG_WIN_TICKS: r_wticks <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item  <= i_in_item;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_sel      <= n_sel;
                    r_hit      <= chain[N].hit;
                    r_free     <= chain[N].taken;
                    r_cur_sent <= chain[N].sent;
                    r_cur_recv <= chain[N].recv;
                    r_state    <= S_UPD;
                end
                S_UPD: begin
                    if (win_end) begin
                        r_elapsed <= '0;
                        r_scan    <= '0;
                        r_cnt     <= '0;
                        r_state   <= S_CNT;
                    end else if (slot_free) begin
                        if (is_tick) begin
                            r_elapsed <= next_elapsed[ELAP_W-1:0];
                        end
                        r_live                 <= n_live;
                        r_out.accepted         <= accepted;
                        r_out.tracked          <= tracked;
                        r_out.window_reset     <= 1'b0;
                        r_out.byte_total       <= total;
                        r_out.live_entries     <= LIVE_W'(n_live);
                        r_out_valid            <= 1'b1;
                        r_state                <= S_IDLE;
                    end
                end
                S_CNT: begin
                    if (r_scan != IW'(N - 1)) begin
                        r_cnt  <= r_cnt + CW'(valid_vec[r_scan]);
                        r_scan <= r_scan + IW'(1);
                    end else if (slot_free) begin
                        r_live                 <= r_cnt + CW'(valid_vec[r_scan]);
                        r_out.accepted         <= 1'b0;
                        r_out.tracked          <= 1'b0;
                        r_out.window_reset     <= 1'b1;
                        r_out.byte_total       <= '0;
                        r_out.live_entries     <= LIVE_W'(r_cnt + CW'(valid_vec[r_scan]));
                        r_out_valid            <= 1'b1;
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(N))
        else $error("live entry count above table size");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(r_sel))
        else $error("more than one cell selected for update");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EVAL))
        else $error("accepted item did not enter match step");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr && cmd.evict))
        else $error("cell write and eviction in the same cycle");
`endif

endmodule
